[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked, reset-qualified concurrent assertions used by the
// checker of the aggregation transfer engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define ATE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: consequent one cycle later");

// The consequent must hold in the same clock as the antecedent.
`define ATE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: consequent in the same cycle");

`endif

[hw/rtl/ate_pkg.sv]
// ----------------------------------------------------------------------------
// ate_pkg
// Shared sizes, operation codes and beat types of the aggregation transfer
// engine.
// ----------------------------------------------------------------------------
package ate_pkg;

	localparam int FINE_SIZE   = 1024;
	localparam int COARSE_SIZE = 64;
	localparam int FINE_W      = $clog2(FINE_SIZE);
	localparam int COARSE_W    = $clog2(COARSE_SIZE);
	localparam int MAT_AW      = 2 * COARSE_W;
	localparam int VALUE_W     = 32;
	localparam int MODE_W      = 4;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_LOAD_PARENT  = 4'd0;
	localparam mode_t MODE_CLEAR_VECTOR = 4'd1;
	localparam mode_t MODE_WRITE_COARSE = 4'd2;
	localparam mode_t MODE_RESTRICT_ADD = 4'd3;
	localparam mode_t MODE_INTERPOLATE  = 4'd4;
	localparam mode_t MODE_READ_VECTOR  = 4'd5;
	localparam mode_t MODE_CLEAR_MATRIX = 4'd6;
	localparam mode_t MODE_MATRIX_ADD   = 4'd7;
	localparam mode_t MODE_READ_MATRIX  = 4'd8;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef struct packed {
		mode_t                      mode;
		logic [FINE_W-1:0]          fine_index;
		logic [FINE_W-1:0]          fine_col;
		logic [COARSE_W-1:0]        coarse_index;
		logic [COARSE_W-1:0]        coarse_col;
		logic signed [VALUE_W-1:0]  value_in;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  value_out;
		logic                       saturated;
	} result_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  sum;
		logic                       ovf;
	} sat_t;

endpackage

[hw/rtl/aggregation_transfer_engine_unit.sv]
// ----------------------------------------------------------------------------
// aggregation_transfer_engine_unit
// Aggregation multigrid transfer engine: parent map, coarse vector and dense
// coarse matrix held in synchronous memories and updated read-modify-write.
// ----------------------------------------------------------------------------
// Path of a beat: load parent, clear vector and write coarse leave the engine idle; reads go
// through ACC (then RES while the output stalls); restrict add and interpolate through PAR and
// ACC; matrix add through PAR, ACC, DIAG and ACC; clear matrix through CLEAR, one entry a cycle.
// A result enters the output register from ACC, as the memory read is registered; interpolate
// first registers the parent lookup in PAR. After reset stall stays high while the coarse matrix
// is swept to zero; the parent map is undefined until loaded.
// ----------------------------------------------------------------------------
module aggregation_transfer_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ate_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output ate_pkg::result_t  result
);

	// Sequencer states. Every item starts in IDLE; adds and interpolation go
	// through PAR (parent lookup returned), reads jump straight to ACC.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAR,
		ST_ACC,
		ST_DIAG,
		ST_RES,
		ST_CLEAR
	} state_t;

	state_t                               state_q;
	logic [ate_pkg::MAT_AW-1:0]           clr_cnt_q;
	logic                                 diag_q;
	logic                                 sat_q;
	logic [ate_pkg::COARSE_SIZE-1:0]      vec_valid_q;
	logic                                 result_valid_q;
	ate_pkg::result_t                     result_q;
	logic signed [ate_pkg::VALUE_W-1:0]   hold_q;

	ate_pkg::item_t                       item_s1;
	logic [ate_pkg::COARSE_W-1:0]         par_row_s2;
	logic [ate_pkg::COARSE_W-1:0]         par_col_s2;
	logic signed [ate_pkg::VALUE_W-1:0]   vec_rd_s3;
	logic                                 vec_hit_s3;
	logic signed [ate_pkg::VALUE_W-1:0]   mat_rd_s3;

	// The three stores. The coarse vector is small enough for a valid bit per
	// entry; the coarse matrix is cleared by a sweep instead.
	logic [ate_pkg::COARSE_W-1:0]         parent_mem [ate_pkg::FINE_SIZE];
	logic signed [ate_pkg::VALUE_W-1:0]   vec_mem    [ate_pkg::COARSE_SIZE];
	logic signed [ate_pkg::VALUE_W-1:0]   mat_mem    [ate_pkg::COARSE_SIZE * ate_pkg::COARSE_SIZE];

	logic                                 accept;
	logic                                 slot_free;
	logic                                 parent_we;
	logic                                 vec_we;
	logic [ate_pkg::COARSE_W-1:0]         vec_waddr;
	logic signed [ate_pkg::VALUE_W-1:0]   vec_wdata;
	logic [ate_pkg::COARSE_W-1:0]         vec_raddr;
	logic                                 mat_we;
	logic [ate_pkg::MAT_AW-1:0]           mat_waddr;
	logic signed [ate_pkg::VALUE_W-1:0]   mat_wdata;
	logic [ate_pkg::MAT_AW-1:0]           mat_raddr;
	logic signed [ate_pkg::VALUE_W-1:0]   vec_eff;
	logic signed [ate_pkg::VALUE_W-1:0]   add_a;
	logic signed [ate_pkg::VALUE_W-1:0]   rd_value;
	ate_pkg::sat_t                        add_res;

	// The engine works on one beat at a time, so it is ready only when idle.
	// The output register lets a new beat in while a result is still waiting.
	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign slot_free    = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The fine and coarse index fields span exactly the sizes of the stores, so
	// every fine index and every loaded parent is in range and needs no check.

	// A coarse vector entry that has not been written since the last clear
	// reads as zero.
	assign vec_eff  = vec_hit_s3 ? vec_rd_s3 : '0;
	assign add_a    = (item_s1.mode == ate_pkg::MODE_RESTRICT_ADD) ? vec_eff : mat_rd_s3;
	assign rd_value = (item_s1.mode == ate_pkg::MODE_INTERPOLATE ||
			item_s1.mode == ate_pkg::MODE_READ_VECTOR) ? vec_eff : mat_rd_s3;

	ate_sat_adder u_add (
		.a   (add_a),
		.b   (item_s1.value_in),
		.res (add_res)
	);

	// Memory port steering.
	always_comb begin
		parent_we = accept && (item.mode == ate_pkg::MODE_LOAD_PARENT);

		vec_we    = (accept && (item.mode == ate_pkg::MODE_WRITE_COARSE)) ||
				((state_q == ST_ACC) && (item_s1.mode == ate_pkg::MODE_RESTRICT_ADD));
		vec_waddr = (state_q == ST_IDLE) ? item.coarse_index : par_row_s2;
		vec_wdata = (state_q == ST_IDLE) ? item.value_in : add_res.sum;
		vec_raddr = (state_q == ST_IDLE) ? item.coarse_index : par_row_s2;

		mat_we    = (state_q == ST_CLEAR) ||
				((state_q == ST_ACC) && (item_s1.mode == ate_pkg::MODE_MATRIX_ADD));
		if (state_q == ST_CLEAR) begin
			mat_waddr = clr_cnt_q;
			mat_wdata = '0;
		end else if (diag_q) begin
			mat_waddr = {par_row_s2, par_row_s2};
			mat_wdata = add_res.sum;
		end else begin
			mat_waddr = {par_row_s2, par_col_s2};
			mat_wdata = add_res.sum;
		end

		case (state_q)
			ST_IDLE: begin
				mat_raddr = {item.coarse_index, item.coarse_col};
			end
			ST_DIAG: begin
				mat_raddr = {par_row_s2, par_row_s2};
			end
			default: begin
				mat_raddr = {par_row_s2, par_col_s2};
			end
		endcase
	end

	// Parent map: one write port and two read ports, for the row and the
	// column parent of a matrix nonzero. Read data stays put until the next
	// accepted beat.
	always_ff @(posedge clk) begin
		if (parent_we) begin
			parent_mem[item.fine_index] <= item.coarse_index;
		end
		if (accept) begin
			par_row_s2 <= parent_mem[item.fine_index];
			par_col_s2 <= parent_mem[item.fine_col];
		end
	end

	// Coarse vector memory. The valid bit of the read entry is registered
	// alongside the data.
	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[vec_waddr] <= vec_wdata;
		end
		vec_rd_s3  <= vec_mem[vec_raddr];
		vec_hit_s3 <= vec_valid_q[vec_raddr];
	end

	// Coarse matrix memory. A write in ACC and the read of the diagonal entry
	// in the following DIAG cycle never fall in the same cycle, so the second
	// add of a diagonal nonzero always sees the first one.
	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= mat_wdata;
		end
		mat_rd_s3 <= mat_mem[mat_raddr];
	end

	// Accepted beat, held for the whole of its processing.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Sequencer, sticky saturation flag, vector valid bits and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			diag_q         <= 1'b0;
			sat_q          <= 1'b0;
			vec_valid_q    <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			hold_q         <= '0;
		end else begin
			if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.mode)
							ate_pkg::MODE_CLEAR_VECTOR: begin
								vec_valid_q <= '0;
								sat_q       <= 1'b0;
							end
							ate_pkg::MODE_WRITE_COARSE: begin
								vec_valid_q[item.coarse_index] <= 1'b1;
							end
							ate_pkg::MODE_RESTRICT_ADD,
							ate_pkg::MODE_INTERPOLATE,
							ate_pkg::MODE_MATRIX_ADD: begin
								diag_q  <= 1'b0;
								state_q <= ST_PAR;
							end
							ate_pkg::MODE_READ_VECTOR,
							ate_pkg::MODE_READ_MATRIX: begin
								diag_q  <= 1'b0;
								state_q <= ST_ACC;
							end
							ate_pkg::MODE_CLEAR_MATRIX: begin
								clr_cnt_q <= '0;
								sat_q     <= 1'b0;
								state_q   <= ST_CLEAR;
							end
							default: begin
								// Parent loads finish in the memory write;
								// unused codes are dropped.
							end
						endcase
					end
				end
				ST_PAR: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					case (item_s1.mode)
						ate_pkg::MODE_RESTRICT_ADD: begin
							vec_valid_q[par_row_s2] <= 1'b1;
							if (add_res.ovf) begin
								sat_q <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
						ate_pkg::MODE_MATRIX_ADD: begin
							if (add_res.ovf) begin
								sat_q <= 1'b1;
							end
							// The first add goes to (row parent, column
							// parent), the second to the row parent diagonal.
							if (diag_q) begin
								state_q <= ST_IDLE;
							end else begin
								diag_q  <= 1'b1;
								state_q <= ST_DIAG;
							end
						end
						default: begin
							if (slot_free) begin
								result_valid_q     <= 1'b1;
								result_q.value_out <= rd_value;
								result_q.saturated <= sat_q;
								state_q            <= ST_IDLE;
							end else begin
								hold_q  <= rd_value;
								state_q <= ST_RES;
							end
						end
					endcase
				end
				ST_DIAG: begin
					state_q <= ST_ACC;
				end
				ST_RES: begin
					if (slot_free) begin
						result_valid_q     <= 1'b1;
						result_q.value_out <= hold_q;
						result_q.saturated <= sat_q;
						state_q            <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + {{(ate_pkg::MAT_AW-1){1'b0}}, 1'b1};
					if (clr_cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ate_sat_adder.sv]
// ----------------------------------------------------------------------------
// ate_sat_adder
// Saturating Q16.16 adder with an overflow indication.
// ----------------------------------------------------------------------------
module ate_sat_adder (
	input  logic signed [ate_pkg::VALUE_W-1:0] a,
	input  logic signed [ate_pkg::VALUE_W-1:0] b,
	output ate_pkg::sat_t                      res
);

	logic signed [ate_pkg::VALUE_W:0] wide;

	// One guard bit: overflow shows as a disagreement of the two top bits.
	assign wide = {a[ate_pkg::VALUE_W-1], a} + {b[ate_pkg::VALUE_W-1], b};

	always_comb begin
		res.ovf = wide[ate_pkg::VALUE_W] != wide[ate_pkg::VALUE_W-1];
		if (!res.ovf) begin
			res.sum = wide[ate_pkg::VALUE_W-1:0];
		end else if (wide[ate_pkg::VALUE_W]) begin
			res.sum = ate_pkg::VALUE_MIN;
		end else begin
			res.sum = ate_pkg::VALUE_MAX;
		end
	end

endmodule

[hw/rtl/ate_checker.sv]
// ----------------------------------------------------------------------------
// ate_checker
// Port-level checks of the aggregation transfer engine, bound to its top
// level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ate_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input ate_pkg::item_t    item,
	input logic              result_valid,
	input logic              result_stall,
	input ate_pkg::result_t  result
);

	logic item_fire;
	logic result_held;
	logic load_fire;
	logic multi_fire;

	assign item_fire   = item_valid && !item_stall;
	assign result_held = result_valid && result_stall;
	assign load_fire   = item_fire && (item.mode == ate_pkg::MODE_LOAD_PARENT);
	assign multi_fire  = item_fire && (item.mode == ate_pkg::MODE_RESTRICT_ADD ||
			item.mode == ate_pkg::MODE_INTERPOLATE ||
			item.mode == ate_pkg::MODE_CLEAR_MATRIX ||
			item.mode == ate_pkg::MODE_MATRIX_ADD);

	// A stalled result beat stays offered and unchanged.
	`ATE_ASSERT_NEXT(a_result_hold, clk, arst_n, result_held, result_valid && $stable(result))

	// A parent load completes in its own cycle.
	`ATE_ASSERT_NEXT(a_load_single, clk, arst_n, load_fire, !item_stall)

	// Adds, interpolation and matrix clears keep the input stalled in the next cycle.
	`ATE_ASSERT_NEXT(a_busy_after_work, clk, arst_n, multi_fire, item_stall)

	// A new result only appears while the engine is busy with its beat.
	`ATE_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(result_valid), $past(item_stall))

endmodule

bind aggregation_transfer_engine_unit ate_checker u_ate_checker (.*);
